// ----- hw/rtl/lcdnd_pkg.sv -----
package lcdnd_pkg;

	// display geometry
	localparam int COLUMNS = 20;
	localparam int ROWS = 4;
	localparam int DEPTH = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int POS_W = $clog2(COLUMNS + 1);
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	// job queue between front and back, a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// lcd constants
	localparam logic [7:0] NIBBLE_MASK = 8'hF0;
	localparam logic [7:0] SET_ADDRESS = 8'h80;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	// input commands
	typedef enum logic [2:0] {
		CMD_WRITE_CHAR = 3'd0,
		CMD_SET_CURSOR = 3'd1,
		CMD_CLEAR      = 3'd2,
		CMD_SEND_BYTE  = 3'd3,
		CMD_SEND_NIB   = 3'd4,
		CMD_REFRESH    = 3'd5
	} cmd_t;

	// configuration register indexes
	localparam logic [2:0] REG_BACKLIGHT = 3'd0;
	localparam logic [2:0] REG_OFFSET_0 = 3'd1;
	localparam logic [2:0] REG_OFFSET_1 = 3'd2;
	localparam logic [2:0] REG_OFFSET_2 = 3'd3;
	localparam logic [2:0] REG_OFFSET_3 = 3'd4;

	// one lcd byte (or init nibble) for the back end to send
	typedef struct packed {
		logic [7:0] value;
		logic       rs;
		logic       nibble_only;
		logic       done;
	} job_t;

endpackage

// ----- hw/rtl/lcdnd_front.sv -----
module lcdnd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [2:0]          command,
	input  logic [7:0]          data_byte,
	input  logic                register_select,
	input  logic [4:0]          column,
	input  logic [2:0]          row,
	input  logic [3:0][6:0]     row_base,
	input  logic                q_full,
	output logic                q_push,
	output lcdnd_pkg::job_t     q_job
);
	import lcdnd_pkg::*;

	typedef enum logic {
		F_IDLE,
		F_PUSH
	} front_state_t;

	front_state_t state_q;

	logic [COL_W-1:0]  cursor_col_q;
	logic [ROW_W-1:0]  cursor_row_q;
	logic [ROW_W-1:0]  refresh_row_q;
	logic [POS_W-1:0]  refresh_pos_q;
	logic              done_q;
	logic [DEPTH-1:0]  valid_q;
	logic [7:0]        mem [DEPTH];
	logic [7:0]        rdata_q;
	logic              hit_q;

	logic              accept;
	logic              cursor_ok;
	logic              refresh_addr;
	logic              refresh_char;
	logic              last_pos;
	logic              last_row;
	logic              last_col;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic              rd_en;

	// item handshake and command decode
	assign full = (state_q != F_IDLE) || q_full;
	assign accept = push && !full;
	assign cursor_ok = (int'(column) < COLUMNS) && (int'(row) < ROWS);
	assign refresh_addr = accept && (command == CMD_REFRESH) && (refresh_pos_q == '0);
	assign refresh_char = accept && (command == CMD_REFRESH) && (refresh_pos_q != '0);
	assign last_pos = int'(refresh_pos_q) == COLUMNS;
	assign last_row = int'(refresh_row_q) == ROWS - 1;
	assign last_col = int'(cursor_col_q) == COLUMNS - 1;
	assign wr_en = accept && (command == CMD_WRITE_CHAR);
	assign rd_en = refresh_char;
	assign wr_addr = ADDR_W'(int'(cursor_row_q) * COLUMNS + int'(cursor_col_q));
	assign rd_addr = ADDR_W'(int'(refresh_row_q) * COLUMNS + int'(refresh_pos_q) - 1);

	// job toward the back end
	always_comb begin
		q_push = 1'b0;
		q_job = '0;
		if (state_q == F_PUSH) begin
			q_push = 1'b1;
			q_job.value = hit_q ? rdata_q : SPACE_CHAR;
			q_job.rs = 1'b1;
			q_job.done = done_q;
		end else if (accept) begin
			unique case (command)
				CMD_SEND_BYTE: begin
					q_push = 1'b1;
					q_job.value = data_byte;
					q_job.rs = register_select;
				end
				CMD_SEND_NIB: begin
					q_push = 1'b1;
					q_job.value = data_byte & NIBBLE_MASK;
					q_job.nibble_only = 1'b1;
				end
				CMD_REFRESH: begin
					q_push = refresh_addr;
					q_job.value = SET_ADDRESS | {1'b0, row_base[2'(refresh_row_q)]};
				end
				default: begin
					q_push = 1'b0;
				end
			endcase
		end
	end

	// control state, cursor and refresh position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			refresh_row_q <= '0;
			refresh_pos_q <= '0;
			done_q <= 1'b0;
			valid_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (refresh_char) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
			if (accept) begin
				unique case (command)
					CMD_WRITE_CHAR: begin
						valid_q[wr_addr] <= 1'b1;
						if (last_col) begin
							cursor_col_q <= '0;
							cursor_row_q <= (int'(cursor_row_q) == ROWS - 1) ? '0 :
								cursor_row_q + ROW_W'(1);
						end else begin
							cursor_col_q <= cursor_col_q + COL_W'(1);
						end
					end
					CMD_SET_CURSOR: begin
						if (cursor_ok) begin
							cursor_col_q <= COL_W'(column);
							cursor_row_q <= ROW_W'(row);
						end
					end
					CMD_CLEAR: begin
						valid_q <= '0;
						cursor_col_q <= '0;
						cursor_row_q <= '0;
					end
					CMD_REFRESH: begin
						done_q <= last_pos && last_row;
						if (last_pos) begin
							refresh_pos_q <= '0;
							refresh_row_q <= last_row ? '0 : refresh_row_q + ROW_W'(1);
						end else begin
							refresh_pos_q <= refresh_pos_q + POS_W'(1);
						end
					end
					default: begin
						done_q <= done_q;
					end
				endcase
			end
		end
	end

	// character store, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= data_byte;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			hit_q <= valid_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/lcdnd_queue.sv -----
module lcdnd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  lcdnd_pkg::job_t wr_job,
	output logic            q_full,
	input  logic            rd,
	output lcdnd_pkg::job_t rd_job,
	output logic            q_empty
);
	import lcdnd_pkg::*;

	job_t              slots [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full = int'(count_q) == QDEPTH;
	assign q_empty = count_q == '0;
	assign do_wr = wr && !q_full;
	assign do_rd = rd && !q_empty;
	assign rd_job = slots[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// job storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ----- hw/rtl/lcdnd_back.sv -----
module lcdnd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            backlight_on,
	input  logic            q_empty,
	input  lcdnd_pkg::job_t q_job,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output logic [7:0]      expander_byte,
	output logic            last_of_run,
	output logic            frame_done
);
	import lcdnd_pkg::*;

	job_t       job_q;
	logic       busy_q;
	logic [1:0] step_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_done_q;

	logic       slot_free;
	logic       take;
	logic       step_last;
	logic [3:0] nib;
	logic [7:0] beat_byte;

	// one output beat per step, two per nibble
	assign slot_free = !out_valid_q || pop;
	assign take = busy_q && slot_free;
	assign step_last = job_q.nibble_only ? (step_q == 2'd1) : (step_q == 2'd3);
	assign q_pop = !q_empty && (!busy_q || (take && step_last));
	assign nib = step_q[1] ? job_q.value[3:0] : job_q.value[7:4];
	assign beat_byte = {nib, backlight_on, !step_q[0], 1'b0, job_q.rs};

	assign empty = !out_valid_q;
	assign expander_byte = out_byte_q;
	assign last_of_run = out_last_q;
	assign frame_done = out_done_q;

	// job register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (take) begin
				busy_q <= !step_last;
				step_q <= step_q + 2'd1;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (take) begin
			out_byte_q <= beat_byte;
			out_last_q <= step_last;
			out_done_q <= job_q.done;
		end
	end

endmodule

// ----- hw/rtl/char_lcd_buffer_nibble_driver.sv -----
// a send or refresh-address item passes the job queue, the back-end job register and the
// output register to the result ports, a refresh-character item the store read register first
// throughput: 4 beats for a byte, 2 for a nibble, one beat per cycle while pop is held;
// the front takes one item a cycle, but none while the queue is full or a store read is pushed
// reset: cursor, refresh position and job queue cleared, store reads as spaces at once,
// backlight on, row offsets 0, 64, 20, 84
module char_lcd_buffer_nibble_driver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] command,
	input  logic [7:0] data_byte,
	input  logic       register_select,
	input  logic [4:0] column,
	input  logic [2:0] row,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] expander_byte,
	output logic       last_of_run,
	output logic       frame_done,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data
);
	import lcdnd_pkg::*;

	logic             backlight_q;
	logic [3:0][6:0]  offsets_q;
	logic             cfg_wr;

	logic             f_push;
	job_t             f_job;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	job_t             q_job;

	// configuration registers
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q <= 1'b1;
			offsets_q[0] <= 7'd0;
			offsets_q[1] <= 7'd64;
			offsets_q[2] <= 7'd20;
			offsets_q[3] <= 7'd84;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_BACKLIGHT: backlight_q <= cfg_data[0];
				REG_OFFSET_0:  offsets_q[0] <= cfg_data;
				REG_OFFSET_1:  offsets_q[1] <= cfg_data;
				REG_OFFSET_2:  offsets_q[2] <= cfg_data;
				REG_OFFSET_3:  offsets_q[3] <= cfg_data;
				default:       backlight_q <= backlight_q;
			endcase
		end
	end

	// command front end with character store
	lcdnd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.command         (command),
		.data_byte       (data_byte),
		.register_select (register_select),
		.column          (column),
		.row             (row),
		.row_base        (offsets_q),
		.q_full          (q_full),
		.q_push          (f_push),
		.q_job           (f_job)
	);

	// job queue
	lcdnd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (f_push),
		.wr_job  (f_job),
		.q_full  (q_full),
		.rd      (q_pop),
		.rd_job  (q_job),
		.q_empty (q_empty)
	);

	// nibble sequencer toward the expander
	lcdnd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.backlight_on  (backlight_q),
		.q_empty       (q_empty),
		.q_job         (q_job),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.expander_byte (expander_byte),
		.last_of_run   (last_of_run),
		.frame_done    (frame_done)
	);

	// the closing beat of a run always drops enable
	a_last_drops_enable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && last_of_run |-> !expander_byte[2])
		else $error("last beat of a run with enable set");

	// every beat carries the backlight register
	a_backlight_bit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> expander_byte[3] == backlight_q)
		else $error("backlight bit does not follow register");

	// the front never pushes into a full queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !q_full)
		else $error("job pushed into full queue");

endmodule

// ----- tb/tb.sv -----
module tb;
	import lcdnd_pkg::*;

	// codes the package leaves unnamed, the block ignores them
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	localparam logic [4:0][2:0] REG_LIST = {REG_OFFSET_3, REG_OFFSET_2, REG_OFFSET_1,
		REG_OFFSET_0, REG_BACKLIGHT};
	localparam int DIR_ROWS = 24;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 21;
	localparam int DRAIN_CYCLES = 16;
	localparam int STUCK_LIMIT = 2000;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data;
		logic       rs;
		logic [4:0] col;
		logic [2:0] row;
	} lcd_item_t;

	// one stimulus row; n_typed > 0 means the beats are written out by hand
	typedef struct packed {
		lcd_item_t       it;
		logic [2:0]      n_typed;
		logic [0:3][7:0] typed;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] xb;
		logic       last;
		logic       done;
	} beat_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [2:0] command = '0;
	logic [7:0] data_byte = '0;
	logic       register_select = 1'b0;
	logic [4:0] column = '0;
	logic [2:0] row = '0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] expander_byte;
	logic       last_of_run;
	logic       frame_done;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	char_lcd_buffer_nibble_driver dut (.*);

	// shadow of the display state
	logic [7:0]       shadow_chars [DEPTH];
	logic [COL_W-1:0] cur_col;
	logic [ROW_W-1:0] cur_row;
	logic [ROW_W-1:0] scan_row;
	logic [POS_W-1:0] scan_pos;
	logic             backlight;
	logic [6:0]       row_ofs [4];

	beat_t     pending_beats [$];
	stim_row_t dir_tab [DIR_ROWS];
	int        bad_beats = 0;
	int        rx_hold = 0;
	int        stuck = 0;
	bit        tx_steady = 1'b0;
	bit        rx_steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic stim_row_t mk_row(logic [2:0] cmd, logic [7:0] data, logic rs,
			logic [4:0] col, logic [2:0] rw, logic [2:0] n, logic [0:3][7:0] bytes);
		stim_row_t s;
		s.it.cmd = cmd;
		s.it.data = data;
		s.it.rs = rs;
		s.it.col = col;
		s.it.row = rw;
		s.n_typed = n;
		s.typed = bytes;
		return s;
	endfunction

	function automatic logic [7:0] nib_beat(logic [3:0] nib, logic rs, logic en);
		return {nib, backlight, en, 1'b0, rs};
	endfunction

	// four expander beats for one lcd byte, high nibble first
	function automatic logic [0:3][7:0] byte_beats(logic [7:0] v, logic rs);
		return {nib_beat(v[7:4], rs, 1'b1), nib_beat(v[7:4], rs, 1'b0),
			nib_beat(v[3:0], rs, 1'b1), nib_beat(v[3:0], rs, 1'b0)};
	endfunction

	// advance the shadow state by one item and return the beats it causes
	task automatic expander_beats_for(input lcd_item_t it, output logic [0:3][7:0] run,
			output int n, output logic done);
		int idx;
		run = '0;
		n = 0;
		done = 1'b0;
		case (it.cmd)
			CMD_WRITE_CHAR: begin
				idx = int'(cur_row) * COLUMNS + int'(cur_col);
				shadow_chars[idx] = it.data;
				if (cur_col == COLUMNS - 1) begin
					cur_col = '0;
					cur_row = (cur_row == ROWS - 1) ? '0 : cur_row + 1'b1;
				end else begin
					cur_col = cur_col + 1'b1;
				end
			end
			CMD_SET_CURSOR: begin
				if (it.col < COLUMNS && it.row < ROWS) begin
					cur_col = it.col[COL_W-1:0];
					cur_row = it.row[ROW_W-1:0];
				end
			end
			CMD_CLEAR: begin
				foreach (shadow_chars[i])
					shadow_chars[i] = SPACE_CHAR;
				cur_col = '0;
				cur_row = '0;
			end
			CMD_SEND_BYTE: begin
				run = byte_beats(it.data, it.rs);
				n = 4;
			end
			CMD_SEND_NIB: begin
				run[0] = nib_beat(it.data[7:4], 1'b0, 1'b1);
				run[1] = nib_beat(it.data[7:4], 1'b0, 1'b0);
				n = 2;
			end
			CMD_REFRESH: begin
				n = 4;
				if (scan_pos == 0) begin
					run = byte_beats(SET_ADDRESS | {1'b0, row_ofs[scan_row]}, 1'b0);
					scan_pos = POS_W'(1);
				end else begin
					idx = int'(scan_row) * COLUMNS + int'(scan_pos) - 1;
					run = byte_beats(shadow_chars[idx], 1'b1);
					if (scan_pos == COLUMNS) begin
						done = (scan_row == ROWS - 1);
						scan_pos = '0;
						scan_row = (scan_row == ROWS - 1) ? '0 : scan_row + 1'b1;
					end else begin
						scan_pos = scan_pos + 1'b1;
					end
				end
			end
			default: ;
		endcase
	endtask

	// offer one item, wait for it to be taken, queue what it should produce
	task automatic send_item(input stim_row_t s);
		int gap;
		int n;
		logic done;
		logic [0:3][7:0] run;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		command <= s.it.cmd;
		data_byte <= s.it.data;
		register_select <= s.it.rs;
		column <= s.it.col;
		row <= s.it.row;
		do @(posedge clk); while (full);
		expander_beats_for(s.it, run, n, done);
		if (s.n_typed != 0) begin
			n = int'(s.n_typed);
			run = s.typed;
			done = 1'b0;
		end
		for (int i = 0; i < n; i++)
			pending_beats.push_back({run[i], i == n - 1, done});
	endtask

	// wait for the queue to drain and the block to go quiet
	task automatic settle();
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all five registers back to back
	task automatic program_regs(input logic [4:0][6:0] vals);
		cfg_valid <= 1'b1;
		for (int i = 0; i < 5; i++) begin
			cfg_index <= REG_LIST[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (REG_LIST[i])
				REG_BACKLIGHT: backlight = vals[i][0];
				REG_OFFSET_0: row_ofs[0] = vals[i];
				REG_OFFSET_1: row_ofs[1] = vals[i];
				REG_OFFSET_2: row_ofs[2] = vals[i];
				REG_OFFSET_3: row_ofs[3] = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic stim_row_t random_row();
		lcd_item_t it;
		int r;
		it.data = 8'($urandom_range(0, 255));
		it.rs = 1'($urandom_range(0, 1));
		it.col = 5'($urandom_range(0, 31));
		it.row = 3'($urandom_range(0, 7));
		r = $urandom_range(0, 99);
		if (r < 55) begin
			it.cmd = CMD_REFRESH;
		end else if (r < 66) begin
			it.cmd = CMD_WRITE_CHAR;
		end else if (r < 73) begin
			it.cmd = CMD_SET_CURSOR;
			// most cursor moves land on the screen
			if (r < 71) begin
				it.col = 5'($urandom_range(0, COLUMNS - 1));
				it.row = 3'($urandom_range(0, ROWS - 1));
			end
		end else if (r < 75) begin
			it.cmd = CMD_CLEAR;
		end else if (r < 87) begin
			it.cmd = CMD_SEND_BYTE;
		end else if (r < 95) begin
			it.cmd = CMD_SEND_NIB;
		end else begin
			it.cmd = (r < 97) ? CMD_SPARE_6 : CMD_SPARE_7;
		end
		return mk_row(it.cmd, it.data, it.rs, it.col, it.row, 3'd0, '0);
	endfunction

	task automatic log_mismatch(input string what, input beat_t want, input beat_t got);
		bad_beats++;
		if (bad_beats <= 10)
			$display("%0t: %s: expected byte %h last %b done %b, got byte %h last %b done %b",
				$realtime, what, want.xb, want.last, want.done, got.xb, got.last, got.done);
	endtask

	// result side: random pop stalls and the beat checker
	always @(posedge clk) begin : result_side
		beat_t got;
		beat_t want;
		if (arst_n && pop && !empty) begin
			got = {expander_byte, last_of_run, frame_done};
			if (pending_beats.size() == 0) begin
				log_mismatch("beat with nothing expected", '0, got);
			end else begin
				want = pending_beats.pop_front();
				if (got !== want)
					log_mismatch("beat mismatch", want, got);
			end
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (rx_hold > 0) begin
			pop <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			pop <= 1'b1;
			rx_hold = rx_steady ? 0 : pick_gap();
		end
	end

	// watchdog on cycles with no beat moving anywhere
	always @(posedge clk) begin
		if (arst_n && !((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))) begin
			stuck = stuck + 1;
			if (stuck >= STUCK_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end else begin
			stuck = 0;
		end
	end

	// shadow state after reset
	initial begin
		foreach (shadow_chars[i])
			shadow_chars[i] = SPACE_CHAR;
		cur_col = '0;
		cur_row = '0;
		scan_row = '0;
		scan_pos = '0;
		backlight = 1'b1;
		row_ofs[0] = 7'd0;
		row_ofs[1] = 7'd64;
		row_ofs[2] = 7'd20;
		row_ofs[3] = 7'd84;
	end

	initial begin : stimulus
		logic [4:0][6:0] regs;
		// refresh from reset: address of row zero, then a space
		dir_tab[0] = mk_row(CMD_REFRESH, 8'h00, 1'b0, 5'd0, 3'd0, 3'd4, 32'h8C880C08);
		dir_tab[1] = mk_row(CMD_REFRESH, 8'hFF, 1'b1, 5'd31, 3'd7, 3'd4, 32'h2D290D09);
		// raw bytes and nibbles at the extremes
		dir_tab[2] = mk_row(CMD_SEND_BYTE, 8'hFF, 1'b1, 5'd31, 3'd7, 3'd4, 32'hFDF9FDF9);
		dir_tab[3] = mk_row(CMD_SEND_BYTE, 8'h00, 1'b0, 5'd0, 3'd0, 3'd4, 32'h0C080C08);
		dir_tab[4] = mk_row(CMD_SEND_NIB, 8'hFF, 1'b0, 5'd0, 3'd0, 3'd2, 32'hFCF80000);
		// low bits and rs do not matter for a nibble
		dir_tab[5] = mk_row(CMD_SEND_NIB, 8'h0F, 1'b1, 5'd0, 3'd0, 3'd2, 32'h0C080000);
		dir_tab[6] = mk_row(CMD_SEND_BYTE, 8'h5A, 1'b1, 5'd10, 3'd2, 3'd0, '0);
		dir_tab[7] = mk_row(CMD_WRITE_CHAR, 8'h41, 1'b0, 5'd0, 3'd0, 3'd0, '0);
		// last cell, then wrap from the bottom row back to the top
		dir_tab[8] = mk_row(CMD_SET_CURSOR, 8'h00, 1'b0, 5'd19, 3'd3, 3'd0, '0);
		dir_tab[9] = mk_row(CMD_WRITE_CHAR, 8'hFF, 1'b0, 5'd0, 3'd0, 3'd0, '0);
		dir_tab[10] = mk_row(CMD_WRITE_CHAR, 8'h00, 1'b1, 5'd0, 3'd0, 3'd0, '0);
		// cursor moves off the screen are dropped
		dir_tab[11] = mk_row(CMD_SET_CURSOR, 8'h00, 1'b0, 5'd20, 3'd0, 3'd0, '0);
		dir_tab[12] = mk_row(CMD_SET_CURSOR, 8'h00, 1'b0, 5'd0, 3'd4, 3'd0, '0);
		dir_tab[13] = mk_row(CMD_SET_CURSOR, 8'hFF, 1'b1, 5'd31, 3'd7, 3'd0, '0);
		dir_tab[14] = mk_row(CMD_WRITE_CHAR, 8'h7E, 1'b0, 5'd0, 3'd0, 3'd0, '0);
		// unused codes
		dir_tab[15] = mk_row(CMD_SPARE_6, 8'hFF, 1'b1, 5'd31, 3'd7, 3'd0, '0);
		dir_tab[16] = mk_row(CMD_SPARE_7, 8'hA5, 1'b0, 5'd5, 3'd1, 3'd0, '0);
		dir_tab[17] = mk_row(CMD_REFRESH, 8'h00, 1'b0, 5'd0, 3'd0, 3'd0, '0);
		dir_tab[18] = mk_row(CMD_REFRESH, 8'h00, 1'b0, 5'd0, 3'd0, 3'd0, '0);
		// clear keeps the refresh position
		dir_tab[19] = mk_row(CMD_CLEAR, 8'h00, 1'b0, 5'd0, 3'd0, 3'd0, '0);
		dir_tab[20] = mk_row(CMD_REFRESH, 8'h00, 1'b0, 5'd0, 3'd0, 3'd0, '0);
		dir_tab[21] = mk_row(CMD_WRITE_CHAR, 8'h80, 1'b0, 5'd0, 3'd0, 3'd0, '0);
		dir_tab[22] = mk_row(CMD_SET_CURSOR, 8'h00, 1'b0, 5'd0, 3'd3, 3'd0, '0);
		dir_tab[23] = mk_row(CMD_REFRESH, 8'h00, 1'b0, 5'd0, 3'd0, 3'd0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with reset settings
		for (int k = 0; k < DIR_ROWS; k++)
			send_item(dir_tab[k]);
		push <= 1'b0;

		// random phases, each with its own register setting
		for (int p = 0; p < PHASES; p++) begin
			settle();
			if (p == 0) begin
				regs = {7'd127, 7'd0, 7'd127, 7'd0, 7'd0};
			end else if (p == 1) begin
				regs = {7'd0, 7'd127, 7'd0, 7'd127, 7'd1};
			end else begin
				for (int i = 0; i < 5; i++)
					regs[i] = 7'($urandom_range(0, 127));
			end
			program_regs(regs);
			tx_steady = (p == 2);
			rx_steady = (p == 2 || p == 4);
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_item(random_row());
			push <= 1'b0;
		end

		settle();
		if (bad_beats == 0 && pending_beats.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/lcdnd_pkg.sv
hw/rtl/lcdnd_front.sv
hw/rtl/lcdnd_queue.sv
hw/rtl/lcdnd_back.sv
hw/rtl/char_lcd_buffer_nibble_driver.sv
tb/tb.sv
